>>> hw/rtl/cmpe_pkg.sv
// Shared types and constants for the current mean / peak / energy meter.
// Configuration indices, reset values and the job record passed front to back.
// No dependencies.
`default_nettype none

package cmpe_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOGGING_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_INTERVAL_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_INTERVAL_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_MV          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_TRACKING      = 3'd4;

    localparam logic        RST_LOGGING_ENABLED    = 1'b0;
    localparam logic [31:0] RST_SAMPLE_INTERVAL_MS = 32'd100;
    localparam logic [31:0] RST_LOG_INTERVAL_MS    = 32'd1000;
    localparam logic [15:0] RST_SUPPLY_MV          = 16'd5000;
    localparam logic        RST_PEAK_TRACKING      = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic        logging_enabled;
        logic [31:0] sample_interval_ms;
        logic [31:0] log_interval_ms;
        logic [15:0] supply_mv;
        logic        peak_tracking;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        stamp_ms;
        logic signed [31:0] sum;
        logic [15:0]        count;
        logic [14:0]        peak;
        logic               peak_valid;
        logic [15:0]        volts_mv;
        logic [31:0]        elapsed_ms;
    } job_t;

endpackage

`default_nettype wire

>>> hw/rtl/current_mean_peak_energy_meter.sv
// Path: an item that closes a window has its record presented after a queue pop,
// a 32-step bit-serial divide for the mean, two multiply stages and one load;
// the load waits while the output is stalled.
// Throughput: one item per cycle at the input while the job queue has room;
// the back end takes a new job only once the record of the last one is loaded.
// Reset: asynchronous, active low; clears marks, window, energy, queue and
// restores configuration defaults. No clearing pass.
`default_nettype none

module current_mean_peak_energy_meter
    import cmpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [31:0]           time_ms,
    input  wire logic [15:0]           current_ma,
    input  wire logic                  sensor_present,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [31:0]                stamp_ms,
    output logic [15:0]                mean_ma,
    output logic [14:0]                peak_ma,
    output logic                       peak_valid,
    output logic [15:0]                volts_mv,
    output logic [31:0]                power_uw,
    output logic [63:0]                energy_nj,
    output logic [31:0]                elapsed_ms
);

    cfg_t cfg_reg, cfg_next;
    logic push;
    job_t push_job;
    logic pop;
    job_t q_head;
    logic q_empty;
    logic q_full;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LOGGING_ENABLED:    cfg_next.logging_enabled    = cfg_data[0];
                CFG_SAMPLE_INTERVAL_MS: cfg_next.sample_interval_ms = cfg_data[31:0];
                CFG_LOG_INTERVAL_MS:    cfg_next.log_interval_ms    = cfg_data[31:0];
                CFG_SUPPLY_MV:          cfg_next.supply_mv          = cfg_data[15:0];
                CFG_PEAK_TRACKING:      cfg_next.peak_tracking      = cfg_data[0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.logging_enabled    <= RST_LOGGING_ENABLED;
            cfg_reg.sample_interval_ms <= RST_SAMPLE_INTERVAL_MS;
            cfg_reg.log_interval_ms    <= RST_LOG_INTERVAL_MS;
            cfg_reg.supply_mv          <= RST_SUPPLY_MV;
            cfg_reg.peak_tracking      <= RST_PEAK_TRACKING;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    cmpe_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .time_ms        (time_ms),
        .current_ma     (current_ma),
        .sensor_present (sensor_present),
        .cfg            (cfg_reg),
        .q_full         (q_full),
        .push           (push),
        .push_job       (push_job)
    );

    cmpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    cmpe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .stamp_ms   (stamp_ms),
        .mean_ma    (mean_ma),
        .peak_ma    (peak_ma),
        .peak_valid (peak_valid),
        .volts_mv   (volts_mv),
        .power_uw   (power_uw),
        .energy_nj  (energy_nj),
        .elapsed_ms (elapsed_ms)
    );

endmodule

`default_nettype wire

>>> hw/rtl/cmpe_front.sv
// Front end: accepts items, keeps the sample window and log mark, and queues
// a job whenever a non-empty window is closed. Depends on cmpe_pkg.
`default_nettype none

module cmpe_front
    import cmpe_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] time_ms,
    input  wire logic [15:0] current_ma,
    input  wire logic        sensor_present,
    input  wire cfg_t        cfg,
    input  wire logic        q_full,
    output logic             push,
    output job_t             push_job
);

    logic [31:0]        sample_mark_reg, sample_mark_next;
    logic [31:0]        log_mark_reg, log_mark_next;
    logic signed [31:0] sum_reg, sum_next;
    logic [15:0]        count_reg, count_next;
    logic [14:0]        peak_reg, peak_next;

    logic               accept;
    logic               sample_due;
    logic               take;
    logic               log_due;
    logic signed [31:0] sum_upd;
    logic [15:0]        count_upd;
    logic [14:0]        peak_upd;
    logic [31:0]        dt;
    logic [31:0]        log_adv;

    assign in_stall = q_full;
    assign accept   = in_valid & ~q_full;

    always_comb
    begin
        sample_due = (time_ms - sample_mark_reg) >= cfg.sample_interval_ms;
        take       = sample_due && (count_reg != 16'hFFFF);
        dt         = time_ms - log_mark_reg;
        log_due    = dt >= cfg.log_interval_ms;
        log_adv    = log_mark_reg + cfg.log_interval_ms;

        sum_upd   = sum_reg;
        count_upd = count_reg;
        peak_upd  = peak_reg;
        if (take)
        begin
            sum_upd   = sum_reg + {{16{current_ma[15]}}, current_ma};
            count_upd = count_reg + 16'd1;
            if (cfg.peak_tracking && ($signed(current_ma) > $signed({1'b0, peak_reg})))
                peak_upd = current_ma[14:0];
        end

        sample_mark_next = sample_mark_reg;
        log_mark_next    = log_mark_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        peak_next        = peak_reg;
        push             = 1'b0;

        push_job.stamp_ms   = time_ms;
        push_job.sum        = sum_upd;
        push_job.count      = count_upd;
        push_job.peak       = cfg.peak_tracking ? peak_upd : 15'd0;
        push_job.peak_valid = cfg.peak_tracking;
        push_job.volts_mv   = cfg.supply_mv;
        push_job.elapsed_ms = dt;

        if (accept && cfg.logging_enabled)
        begin
            if (!sensor_present)
            begin
                sum_next   = '0;
                count_next = '0;
                peak_next  = '0;
            end
            else
            begin
                if (sample_due)
                    sample_mark_next = time_ms;
                sum_next   = sum_upd;
                count_next = count_upd;
                peak_next  = peak_upd;
                if (log_due)
                begin
                    log_mark_next = (log_adv == 32'd0) ? time_ms : log_adv;
                    push          = (count_upd != 16'd0);
                    sum_next      = '0;
                    count_next    = '0;
                    peak_next     = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_mark_reg <= '0;
            log_mark_reg    <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            peak_reg        <= '0;
        end
        else
        begin
            sample_mark_reg <= sample_mark_next;
            log_mark_reg    <= log_mark_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            peak_reg        <= peak_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cmpe_queue.sv
// Short job queue between the front and back ends, flop based.
// Depends on cmpe_pkg for the job record.
`default_nettype none

module cmpe_queue
    import cmpe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      empty,
    output logic      full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (!do_push && do_pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/cmpe_back.sv
// Back end: bit-serial divide for the mean, power and energy multiplies,
// energy accumulator and output register. Depends on cmpe_pkg.
`default_nettype none

module cmpe_back
    import cmpe_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_empty,
    input  wire job_t q_head,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic [31:0] stamp_ms,
    output logic [15:0] mean_ma,
    output logic [14:0] peak_ma,
    output logic        peak_valid,
    output logic [15:0] volts_mv,
    output logic [31:0] power_uw,
    output logic [63:0] energy_nj,
    output logic [31:0] elapsed_ms
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_ACC  = 3'd4;

    logic [2:0]         state_reg, state_next;
    job_t               job_reg;
    logic [31:0]        quo_reg, quo_next;
    logic [15:0]        rem_reg, rem_next;
    logic [4:0]         step_reg, step_next;
    logic               neg_reg;
    logic [15:0]        mean_reg;
    logic signed [32:0] power_reg;
    logic [63:0]        de_reg;
    logic [63:0]        energy_reg;
    logic               out_valid_reg, out_valid_next;

    logic [16:0]        shifted;
    logic               ge;
    logic [31:0]        mag;
    logic [15:0]        mean_c;
    logic signed [32:0] mean_x;
    logic signed [32:0] mv_x;
    logic signed [32:0] prod1;
    logic signed [65:0] pow_x;
    logic signed [65:0] dt_x;
    logic signed [65:0] prod2;
    logic               out_free;
    logic               load_out;

    assign out_free  = ~out_valid_reg | ~out_stall;
    assign load_out  = (state_reg == ST_ACC) && out_free;
    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[31]};
        ge       = shifted >= {1'b0, job_reg.count};
        mag      = q_head.sum[31] ? 32'(-q_head.sum) : q_head.sum;
        mean_c   = neg_reg ? 16'(-quo_reg[15:0]) : quo_reg[15:0];
        mean_x   = {{17{mean_c[15]}}, mean_c};
        mv_x     = {17'd0, job_reg.volts_mv};
        prod1    = mean_x * mv_x;
        pow_x    = {{33{power_reg[32]}}, power_reg};
        dt_x     = {34'd0, job_reg.elapsed_ms};
        prod2    = pow_x * dt_x;

        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg & out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    quo_next   = mag;
                    rem_next   = '0;
                    step_next  = 5'd31;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next  = ge ? 16'(shifted - {1'b0, job_reg.count}) : shifted[15:0];
                quo_next  = {quo_reg[30:0], ge};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd0)
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_head;
            neg_reg <= q_head.sum[31];
        end
        if (state_reg == ST_MUL1)
        begin
            mean_reg  <= mean_c;
            power_reg <= prod1;
        end
        if (state_reg == ST_MUL2)
            de_reg <= prod2[63:0];
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
        if (load_out)
        begin
            stamp_ms   <= job_reg.stamp_ms;
            mean_ma    <= mean_reg;
            peak_ma    <= job_reg.peak;
            peak_valid <= job_reg.peak_valid;
            volts_mv   <= job_reg.volts_mv;
            power_uw   <= power_reg[31:0];
            energy_nj  <= energy_reg + de_reg;
            elapsed_ms <= job_reg.elapsed_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
                energy_reg <= energy_reg + de_reg;
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while back end busy");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> (state_reg == ST_DIV) || (state_reg == ST_MUL1))
        else $error("divider left early");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg && (energy_nj == energy_reg))
        else $error("record load lost");

    a_energy_only_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        (energy_reg != $past(energy_reg)) |-> $past(load_out))
        else $error("energy changed without a record");

endmodule

`default_nettype wire
